[hw/rtl/pps_pkg.sv]
package pps_pkg;

  // defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF     = 16;
  localparam int PRIORITY_BITS_DEF = 3;

  // work units per task, fixed by the load word format
  localparam int BURST_BITS = 8;

  // in_tuser codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // control from the sequencer to the picker
  typedef struct packed {
    logic clear;   // start of a new scan
    logic sample;  // read data from the task memory is valid this cycle
  } pick_ctl_t;

  // width rounded up to whole bytes
  function automatic int byte_round(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

[hw/rtl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler.
// Input stream (in_*): one word per command. in_tuser selects the command:
// load writes a task slot (arrival, burst, priority), tick runs one time step.
// Loads give no result and are taken one per cycle while the block is idle.
// Result stream (out_*): one word per tick, naming the tick, the slot that ran
// and, when that task finished, its completion, turnaround and waiting times.
// Steps: a tick scans the task memory one slot per cycle through its single
// read port, then does the turnaround subtract and memory write-back in the
// calc state, and forms the result in the out state, which waits for a free
// output register.
// The output register holds a result while the next command is accepted; a
// stalled receiver only holds back the end of the following tick.
// Reset (rst_n low, synchronous) empties every slot at once and zeroes the
// tick counter; the block is ready as soon as reset is released.
// The tick counter saturates at all ones.
module preemptive_priority_scheduler #(
  parameter int NUM_SLOTS     = pps_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS     = pps_pkg::TIME_BITS_DEF,
  parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEF,
  localparam int SLOT_BITS    = $clog2(NUM_SLOTS),
  localparam int IN_DATA_W    = pps_pkg::byte_round(SLOT_BITS + TIME_BITS
                                  + pps_pkg::BURST_BITS + PRIORITY_BITS),
  localparam int OUT_DATA_W   = pps_pkg::byte_round(4 * TIME_BITS + SLOT_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // low to high: slot, arrival, burst, priority_req
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // low to high: tick_time, ran_slot, completion, turnaround, waiting
  output logic [OUT_DATA_W-1:0] out_tdata,
  // low to high: ran_valid, finished
  output logic [1:0]            out_tuser
);

  localparam int BB    = pps_pkg::BURST_BITS;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // input word fields
  logic [SLOT_BITS-1:0]     in_slot;
  logic [TIME_BITS-1:0]     in_arrival;
  logic [BB-1:0]            in_burst;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic                     in_acc;

  assign in_slot    = in_tdata[SLOT_BITS-1:0];
  assign in_arrival = in_tdata[SLOT_BITS +: TIME_BITS];
  assign in_burst   = in_tdata[SLOT_BITS + TIME_BITS +: BB];
  assign in_prio    = in_tdata[SLOT_BITS + TIME_BITS + BB +: PRIORITY_BITS];
  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);

  // time and scan bookkeeping
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic [TIME_BITS-1:0] comp_r, comp_nxt;   // tick + 1, saturated
  logic [TIME_BITS-1:0] turn_r, turn_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;   // a read is returning this cycle
  logic [SLOT_BITS-1:0] pend_idx_r, pend_idx_nxt;
  logic                 issue;

  assign issue = (state_r == ST_SCAN) && (cnt_r < CNT_W'(NUM_SLOTS));

  // memory port signals
  logic                     mem_wr_en;
  logic [SLOT_BITS-1:0]     mem_wr_addr;
  logic [TIME_BITS-1:0]     mem_wr_arrival;
  logic [BB-1:0]            mem_wr_rem;
  logic [BB-1:0]            mem_wr_orig;
  logic [PRIORITY_BITS-1:0] mem_wr_prio;
  logic [TIME_BITS-1:0]     rd_arrival;
  logic [BB-1:0]            rd_rem;
  logic [BB-1:0]            rd_orig;
  logic [PRIORITY_BITS-1:0] rd_prio;

  // picker results
  pps_pkg::pick_ctl_t       pick_ctl;
  logic                     found;
  logic [SLOT_BITS-1:0]     best_idx;
  logic [TIME_BITS-1:0]     best_arrival;
  logic [BB-1:0]            best_rem;
  logic [BB-1:0]            best_orig;
  logic [PRIORITY_BITS-1:0] best_prio;
  logic                     finished;

  assign finished = found && (best_rem == BB'(1));

  assign pick_ctl.clear  = in_acc && (in_tuser == pps_pkg::OP_TICK);
  assign pick_ctl.sample = pend_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;
  logic                  out_free;
  logic [TIME_BITS-1:0]  wait_val;

  assign out_free = !out_valid_r || out_tready;
  // waiting floors at zero once time has saturated
  assign wait_val = (turn_r >= TIME_BITS'(best_orig)) ? (turn_r - TIME_BITS'(best_orig)) : '0;

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    comp_nxt      = comp_r;
    turn_nxt      = turn_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = issue;
    pend_idx_nxt  = cnt_r[SLOT_BITS-1:0];
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    mem_wr_en      = 1'b0;
    mem_wr_addr    = in_slot;
    mem_wr_arrival = in_arrival;
    mem_wr_rem     = in_burst;
    mem_wr_orig    = in_burst;
    mem_wr_prio    = in_prio;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == pps_pkg::OP_LOAD) begin
            // out-of-range slots are dropped
            mem_wr_en = (CNT_W'(in_slot) < CNT_W'(NUM_SLOTS));
          end else begin
            cnt_nxt   = '0;
            comp_nxt  = (tick_r == TIME_MAX) ? TIME_MAX : tick_r + TIME_BITS'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          // last read returns this cycle, picker settles at the edge
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        turn_nxt       = comp_r - best_arrival;
        mem_wr_en      = found;
        mem_wr_addr    = best_idx;
        mem_wr_arrival = best_arrival;
        mem_wr_rem     = best_rem - BB'(1);
        mem_wr_orig    = best_orig;
        mem_wr_prio    = best_prio;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[TIME_BITS-1:0] = tick_r;
          if (found) begin
            out_data_nxt[TIME_BITS +: SLOT_BITS] = best_idx;
          end
          if (finished) begin
            out_data_nxt[TIME_BITS + SLOT_BITS +: TIME_BITS]         = comp_r;
            out_data_nxt[2 * TIME_BITS + SLOT_BITS +: TIME_BITS]     = turn_r;
            out_data_nxt[3 * TIME_BITS + SLOT_BITS +: TIME_BITS]     = wait_val;
          end
          out_user_nxt = {finished, found};
          tick_nxt     = comp_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    comp_r     <= comp_nxt;
    turn_r     <= turn_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  pps_task_mem #(
    .NUM_SLOTS     (NUM_SLOTS),
    .TIME_BITS     (TIME_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_mem (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (mem_wr_en),
    .wr_addr      (mem_wr_addr),
    .wr_arrival   (mem_wr_arrival),
    .wr_remaining (mem_wr_rem),
    .wr_orig      (mem_wr_orig),
    .wr_prio      (mem_wr_prio),
    .rd_en        (issue),
    .rd_addr      (cnt_r[SLOT_BITS-1:0]),
    .rd_arrival   (rd_arrival),
    .rd_remaining (rd_rem),
    .rd_orig      (rd_orig),
    .rd_prio      (rd_prio)
  );

  pps_picker #(
    .NUM_SLOTS     (NUM_SLOTS),
    .TIME_BITS     (TIME_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_picker (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (pick_ctl),
    .now            (tick_r),
    .idx            (pend_idx_r),
    .arrival        (rd_arrival),
    .remaining      (rd_rem),
    .orig           (rd_orig),
    .prio           (rd_prio),
    .found          (found),
    .best_idx       (best_idx),
    .best_arrival   (best_arrival),
    .best_remaining (best_rem),
    .best_orig      (best_orig),
    .best_prio      (best_prio)
  );

  // no write may land in the memory while a scan is reading it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_wr_en)
    else $error("task memory written during scan");

  // a finished task must also have run
  a_finish_implies_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_user_r[0] || !out_user_r[1]))
    else $error("finished flag without a running slot");

  // time never goes backward
  a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (tick_r >= $past(tick_r)))
    else $error("tick counter went backward");

  // scan counter stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_SLOTS))
    else $error("scan counter ran past the table");

endmodule

[hw/rtl/pps_task_mem.sv]
module pps_task_mem #(
  parameter int NUM_SLOTS     = pps_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS     = pps_pkg::TIME_BITS_DEF,
  parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEF,
  localparam int SLOT_BITS    = $clog2(NUM_SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [SLOT_BITS-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0]     wr_arrival,
  input  logic [pps_pkg::BURST_BITS-1:0] wr_remaining,
  input  logic [pps_pkg::BURST_BITS-1:0] wr_orig,
  input  logic [PRIORITY_BITS-1:0] wr_prio,
  input  logic                     rd_en,
  input  logic [SLOT_BITS-1:0]     rd_addr,
  output logic [TIME_BITS-1:0]     rd_arrival,
  output logic [pps_pkg::BURST_BITS-1:0] rd_remaining,
  output logic [pps_pkg::BURST_BITS-1:0] rd_orig,
  output logic [PRIORITY_BITS-1:0] rd_prio
);

  localparam int BB      = pps_pkg::BURST_BITS;
  localparam int ENTRY_W = TIME_BITS + 2 * BB + PRIORITY_BITS;

  // entry: {prio, orig, remaining, arrival}
  logic [ENTRY_W-1:0]   mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic [ENTRY_W-1:0]   rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_prio, wr_orig, wr_remaining, wr_arrival};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // a slot never written reads as all zero (empty)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_arrival   = rd_valid_r ? rd_data_r[TIME_BITS-1:0] : '0;
  assign rd_remaining = rd_valid_r ? rd_data_r[TIME_BITS +: BB] : '0;
  assign rd_orig      = rd_valid_r ? rd_data_r[TIME_BITS + BB +: BB] : '0;
  assign rd_prio      = rd_valid_r ? rd_data_r[TIME_BITS + 2 * BB +: PRIORITY_BITS] : '0;

endmodule

[hw/rtl/pps_picker.sv]
module pps_picker #(
  parameter int NUM_SLOTS     = pps_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS     = pps_pkg::TIME_BITS_DEF,
  parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEF,
  localparam int SLOT_BITS    = $clog2(NUM_SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pps_pkg::pick_ctl_t       ctl,
  input  logic [TIME_BITS-1:0]     now,
  input  logic [SLOT_BITS-1:0]     idx,
  input  logic [TIME_BITS-1:0]     arrival,
  input  logic [pps_pkg::BURST_BITS-1:0] remaining,
  input  logic [pps_pkg::BURST_BITS-1:0] orig,
  input  logic [PRIORITY_BITS-1:0] prio,
  output logic                     found,
  output logic [SLOT_BITS-1:0]     best_idx,
  output logic [TIME_BITS-1:0]     best_arrival,
  output logic [pps_pkg::BURST_BITS-1:0] best_remaining,
  output logic [pps_pkg::BURST_BITS-1:0] best_orig,
  output logic [PRIORITY_BITS-1:0] best_prio
);

  logic                     found_r;
  logic [PRIORITY_BITS-1:0] best_prio_r;
  logic [SLOT_BITS-1:0]     best_idx_r;
  logic [TIME_BITS-1:0]     best_arrival_r;
  logic [pps_pkg::BURST_BITS-1:0] best_rem_r;
  logic [pps_pkg::BURST_BITS-1:0] best_orig_r;
  logic                     eligible;
  logic                     take;

  // slots arrive in ascending order, so strict less-than keeps the lowest on a tie
  assign eligible = (arrival <= now) && (remaining != '0);
  assign take     = ctl.sample && eligible && (!found_r || (prio < best_prio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_prio_r    <= prio;
      best_idx_r     <= idx;
      best_arrival_r <= arrival;
      best_rem_r     <= remaining;
      best_orig_r    <= orig;
    end
  end

  assign found          = found_r;
  assign best_idx       = best_idx_r;
  assign best_arrival   = best_arrival_r;
  assign best_remaining = best_rem_r;
  assign best_orig      = best_orig_r;
  assign best_prio      = best_prio_r;

endmodule

[tb/tb_preemptive_priority_scheduler.sv]
module tb_preemptive_priority_scheduler;

  localparam int NSLOT       = 16;
  localparam int RAND_WORDS  = 780;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int SETTLE      = 24;    // one tick's latency plus margin
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake
  localparam bit [15:0] T_MAX = 16'hFFFF;

  // one result word, unpacked
  typedef struct {
    bit [15:0] tick_time;
    bit        ran_valid;
    bit [3:0]  ran_slot;
    bit        finished;
    bit [15:0] completion;
    bit [15:0] turnaround;
    bit [15:0] waiting;
  } tick_result_t;

  // Task table shadow plus the queue of tick results still owed by the block.
  class sched_scoreboard;
    bit [15:0] arrival_tbl[NSLOT];
    bit [7:0]  left_tbl[NSLOT];
    bit [7:0]  burst_tbl[NSLOT];
    bit [2:0]  prio_tbl[NSLOT];
    bit [15:0] now_tick;
    tick_result_t owed[$];
    int errors;

    function void note_word(pps_pkg::op_t op, bit [3:0] slot, bit [15:0] arrival,
                            bit [7:0] burst, bit [2:0] prio);
      tick_result_t r;
      bit found;
      int best;
      bit [2:0] best_prio;
      if (op == pps_pkg::OP_LOAD) begin
        // a load replaces the whole slot, remaining work included
        arrival_tbl[slot] = arrival;
        left_tbl[slot]    = burst;
        burst_tbl[slot]   = burst;
        prio_tbl[slot]    = prio;
        return;
      end
      found = 1'b0;
      best = 0;
      best_prio = '0;
      // strict less-than keeps the lowest slot on a priority tie
      for (int i = 0; i < NSLOT; i++) begin
        if (arrival_tbl[i] <= now_tick && left_tbl[i] != 0) begin
          if (!found || prio_tbl[i] < best_prio) begin
            found = 1'b1;
            best = i;
            best_prio = prio_tbl[i];
          end
        end
      end
      r = '{default: '0};
      r.tick_time = now_tick;
      if (found) begin
        r.ran_valid = 1'b1;
        r.ran_slot  = best[3:0];
        left_tbl[best]--;
        if (left_tbl[best] == 0) begin
          r.finished   = 1'b1;
          r.completion = (now_tick == T_MAX) ? T_MAX : now_tick + 16'd1;
          r.turnaround = r.completion - arrival_tbl[best];
          // only reachable short after saturation: clamp to zero
          r.waiting    = (r.turnaround >= burst_tbl[best]) ?
                         r.turnaround - burst_tbl[best] : 16'd0;
        end
      end
      owed.push_back(r);
      if (now_tick != T_MAX) now_tick++;
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(bit [71:0] data, bit [1:0] user);
      tick_result_t e;
      if (owed.size() == 0) begin
        $error("result word with no tick outstanding: data %h user %b", data, user);
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp_field("tick_time",  e.tick_time,  data[15:0]);
      cmp_field("ran_valid",  e.ran_valid,  user[0]);
      cmp_field("ran_slot",   e.ran_slot,   data[19:16]);
      cmp_field("finished",   e.finished,   user[1]);
      cmp_field("completion", e.completion, data[35:20]);
      cmp_field("turnaround", e.turnaround, data[51:36]);
      cmp_field("waiting",    e.waiting,    data[67:52]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // low to high: slot, arrival, burst, priority_req, pad
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // low to high: tick_time, ran_slot, completion, turnaround, waiting
  logic [1:0]  out_tuser;  // low to high: ran_valid, finished

  sched_scoreboard sb = new;

  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit rx_hold_req = 1'b0;
  int quiet_cycles = 0;

  preemptive_priority_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // offer one word, optionally after a short gap; valid stays high afterwards
  task automatic send_word(input pps_pkg::op_t op, input bit [3:0] slot,
                           input bit [15:0] arrival, input bit [7:0] burst,
                           input bit [2:0] prio);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, prio, burst, arrival, slot};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, slot, arrival, burst, prio);
  endtask

  task automatic send_tick();
    send_word(pps_pkg::OP_TICK, 4'($urandom), 16'($urandom), 8'($urandom), 3'($urandom));
  endtask

  // mostly tasks that arrive soon and finish quickly, so that the table stays busy
  task automatic load_random();
    bit [15:0] arrival;
    bit [7:0]  burst;
    case ($urandom_range(0, 9))
      0: arrival = 16'($urandom_range(0, 16'hFFFF));
      1: arrival = (sb.now_tick > 16'd30) ? sb.now_tick - 16'($urandom_range(0, 30)) : 16'd0;
      default: arrival = (sb.now_tick > T_MAX - 16'd20) ? T_MAX :
                         sb.now_tick + 16'($urandom_range(0, 20));
    endcase
    case ($urandom_range(0, 9))
      0: burst = 8'd0;
      1: burst = 8'($urandom_range(0, 255));
      default: burst = 8'($urandom_range(1, 8));
    endcase
    send_word(pps_pkg::OP_LOAD, 4'($urandom_range(0, NSLOT - 1)), arrival, burst,
              3'($urandom_range(0, 7)));
  endtask

  // sender goes quiet until every owed result is back, then lets the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // receiver ready: random stall bursts, plus one long hold-off on request
  initial begin : rx_ready
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: cycles in which neither side hands over a word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stim
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= pps_pkg::OP_LOAD;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, extremes, zero burst, ties, preemption, reload
    send_tick();                                      // nothing loaded: idle tick
    send_word(pps_pkg::OP_LOAD, 4'd0,  16'd0,      8'd1,   3'd7);
    send_tick();                                      // one-unit task finishes
    send_word(pps_pkg::OP_LOAD, 4'd3,  16'd0,      8'd0,   3'd0);  // empty slot, never runs
    send_word(pps_pkg::OP_LOAD, 4'd15, T_MAX,      8'd255, 3'd7);
    send_word(pps_pkg::OP_LOAD, 4'd5,  16'd0,      8'd2,   3'd2);
    send_word(pps_pkg::OP_LOAD, 4'd9,  16'd0,      8'd2,   3'd2);  // tie with slot 5
    send_word(pps_pkg::OP_LOAD, 4'd7,  16'd4,      8'd1,   3'd1);  // arrives later, runs ahead of slot 9
    send_tick();
    send_word(pps_pkg::OP_LOAD, 4'd5,  16'd0,      8'd3,   3'd0);  // reload while running
    repeat (7) send_tick();
    send_word(pps_pkg::OP_LOAD, 4'd10, 16'd0,      8'd255, 3'd0);
    send_word(pps_pkg::OP_LOAD, 4'd12, 16'h8000,   8'h80,  3'd4);
    repeat (2) send_tick();
    send_word(pps_pkg::OP_LOAD, 4'd10, 16'd0,      8'd0,   3'd0);  // reload to empty
    send_tick();
    drain_results();

    // random: about a third loads, the rest ticks
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 100 == 0) begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if (n == 300) begin
        // sender keeps offering while the receiver holds off
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
      end
      if (n == 600) drain_results();
      if ($urandom_range(0, 99) < 35) load_random();
      else send_tick();
    end
    drain_results();

    // last stretch, no idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_word(pps_pkg::OP_LOAD, 4'd1, sb.now_tick,     8'd200, 3'd0);  // long runner
    send_word(pps_pkg::OP_LOAD, 4'd2, T_MAX,           8'd3,   3'd1);  // never arrives here
    send_word(pps_pkg::OP_LOAD, 4'd4, T_MAX - 16'd600, 8'd20,  3'd2);
    for (int n = 0; n < 100; n++) begin
      if ($urandom_range(0, 15) == 0) load_random();
      else send_tick();
    end
    drain_results();

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
